### src/rimt_pkg.sv
// ----------------------------------------------------------------------------
// rimt_pkg: shared types and constants for the request id match tracker
// Beat layouts, opcodes, table geometry and the sequencer-to-table command.
// ----------------------------------------------------------------------------
`default_nettype none

package rimt_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int ID_W    = 16;
	localparam int TIME_W  = 63;

	localparam logic OP_REGISTER = 1'b0;
	localparam logic OP_MATCH    = 1'b1;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [ID_W-1:0]   id_t;
	typedef logic [TIME_W-1:0] ts_t;

	typedef struct packed {
		logic operation;
		id_t  message_id;
		ts_t  timestamp;
	} in_item_t;

	typedef struct packed {
		logic found;
		ts_t  request_time;
	} out_item_t;

	// command from the sequencer to the entry table
	typedef struct packed {
		logic wr_en;
		id_t  wr_id;
		ts_t  wr_ts;
		logic clr_en;
		idx_t rd_idx;
	} tbl_cmd_t;

	// entry seen at the read index
	typedef struct packed {
		logic outstanding;
		id_t  id;
		ts_t  ts;
	} tbl_entry_t;

endpackage

`default_nettype wire

### src/rimt_cmp.sv
// ----------------------------------------------------------------------------
// rimt_cmp: shared time comparator
// Unsigned less-than on send times, used by both the search and clear passes.
// ----------------------------------------------------------------------------
`default_nettype none

module rimt_cmp (
	input  wire rimt_pkg::ts_t a,
	input  wire rimt_pkg::ts_t b,
	output logic               lt
);

	assign lt = (a < b);

endmodule

`default_nettype wire

### src/rimt_table.sv
// ----------------------------------------------------------------------------
// rimt_table: ring of request entries
// Outstanding flags, ids and send times, with a wrapping write pointer and a
// single read index driven by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module rimt_table (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire rimt_pkg::tbl_cmd_t cmd,
	output rimt_pkg::tbl_entry_t  rd
);

	localparam rimt_pkg::idx_t LAST_IDX = rimt_pkg::IDX_W'(rimt_pkg::ENTRIES - 1);

	logic [rimt_pkg::ENTRIES-1:0] outstanding_q;
	rimt_pkg::id_t                id_q [rimt_pkg::ENTRIES];
	rimt_pkg::ts_t                ts_q [rimt_pkg::ENTRIES];
	rimt_pkg::idx_t               wr_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
			wr_ptr_q      <= '0;
		end else begin
			if (cmd.clr_en) begin
				outstanding_q[cmd.rd_idx] <= 1'b0;
			end
			if (cmd.wr_en) begin
				outstanding_q[wr_ptr_q] <= 1'b1;
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
		end
	end

	// payload needs no reset: only outstanding entries are ever looked at
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			id_q[wr_ptr_q] <= cmd.wr_id;
			ts_q[wr_ptr_q] <= cmd.wr_ts;
		end
	end

	assign rd.outstanding = outstanding_q[cmd.rd_idx];
	assign rd.id          = id_q[cmd.rd_idx];
	assign rd.ts          = ts_q[cmd.rd_idx];

endmodule

`default_nettype wire

### src/rimt_seq.sv
// ----------------------------------------------------------------------------
// rimt_seq: match sequencer
// Steps one entry a cycle through a search pass, then a clear pass on a hit,
// sharing a single comparator, and holds the response in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rimt_seq (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     req_valid,
	output logic                    req_stall,
	input  wire rimt_pkg::in_item_t req,
	output logic                    rsp_valid,
	input  wire                     rsp_stall,
	output rimt_pkg::out_item_t     rsp,
	output rimt_pkg::tbl_cmd_t      cmd,
	input  wire rimt_pkg::tbl_entry_t rd,
	output rimt_pkg::ts_t           cmp_a,
	output rimt_pkg::ts_t           cmp_b,
	input  wire                     cmp_lt
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_CLEAR = 2'd2;
	localparam logic [1:0] ST_RESP  = 2'd3;

	localparam rimt_pkg::idx_t LAST_IDX = rimt_pkg::IDX_W'(rimt_pkg::ENTRIES - 1);

	logic [1:0]          state_q;
	rimt_pkg::idx_t      idx_q;
	rimt_pkg::idx_t      pick_q;
	rimt_pkg::id_t       id_q;
	rimt_pkg::ts_t       best_ts_q;
	logic                have_q;
	logic                rsp_valid_q;
	rimt_pkg::out_item_t rsp_q;

	logic accept;
	logic hit;
	logic last;
	logic rsp_load;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign last      = (idx_q == LAST_IDX);

	assign cmp_a = rd.ts;
	assign cmp_b = best_ts_q;

	// candidate in the search pass; first hit needs no compare
	assign hit = (state_q == ST_SCAN) && rd.outstanding && (rd.id == id_q)
		&& (!have_q || cmp_lt);

	assign rsp_load = (state_q == ST_RESP) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		cmd.wr_en  = accept && (req.operation == rimt_pkg::OP_REGISTER);
		cmd.wr_id  = req.message_id;
		cmd.wr_ts  = req.timestamp;
		cmd.rd_idx = idx_q;
		// drop the pick itself and everything sent strictly earlier
		cmd.clr_en = (state_q == ST_CLEAR) && rd.outstanding
			&& (cmp_lt || (idx_q == pick_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			have_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (req.operation == rimt_pkg::OP_MATCH)) begin
						idx_q   <= '0;
						have_q  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						have_q <= 1'b1;
					end
					idx_q <= last ? '0 : idx_q + 1'b1;
					if (last) begin
						state_q <= (have_q || hit) ? ST_CLEAR : ST_RESP;
					end
				end
				ST_CLEAR: begin
					idx_q <= last ? '0 : idx_q + 1'b1;
					if (last) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q <= req.message_id;
		end
		if (hit) begin
			pick_q    <= idx_q;
			best_ts_q <= rd.ts;
		end
		if (rsp_load) begin
			rsp_q.found        <= have_q;
			rsp_q.request_time <= have_q ? best_ts_q : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

### src/request_id_match_tracker_unit.sv
// ----------------------------------------------------------------------------
// request_id_match_tracker_unit: outstanding request table with id matching
// Registers sent requests in a ring and matches responses against them.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one beat per item.
//   A register beat (operation 0) writes the entry at the write pointer,
//   marks it outstanding and advances the pointer; it gives no response and
//   raises no stall, so register beats can follow each other every cycle.
//   A match beat (operation 1) gives exactly one rsp beat: found and the
//   earliest matching send time, or found 0 and time 0.
//   A match with a hit runs a search pass and then a clear pass over every
//   entry, both through the one shared time comparator, between the accept
//   and the response load. A miss skips the clear pass. req_stall is high
//   while a match is in flight.
//   The response sits in an output register; a new item is taken while it
//   waits. If rsp_stall holds the register full, the next match waits in its
//   response step until the register frees.
//   Reset (arst_n low) clears all outstanding flags, the write pointer and
//   the response valid; entry ids and times are left as they are.
// ----------------------------------------------------------------------------
`default_nettype none

module request_id_match_tracker_unit (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      req_valid,
	output logic                     req_stall,
	input  wire rimt_pkg::in_item_t  req,
	output logic                     rsp_valid,
	input  wire                      rsp_stall,
	output rimt_pkg::out_item_t      rsp
);

	rimt_pkg::tbl_cmd_t   cmd;
	rimt_pkg::tbl_entry_t rd;
	rimt_pkg::ts_t        cmp_a;
	rimt_pkg::ts_t        cmp_b;
	logic                 cmp_lt;

	rimt_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cmd       (cmd),
		.rd        (rd),
		.cmp_a     (cmp_a),
		.cmp_b     (cmp_b),
		.cmp_lt    (cmp_lt)
	);

	rimt_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rd     (rd)
	);

	rimt_cmp u_cmp (
		.a  (cmp_a),
		.b  (cmp_b),
		.lt (cmp_lt)
	);

endmodule

`default_nettype wire

### src/rimt_checker.sv
// ----------------------------------------------------------------------------
// rimt_checker: port-level checks for the match tracker
// Watches the top level's channels and flags timing and payload slips.
// ----------------------------------------------------------------------------
`default_nettype none

module rimt_checker (
	input wire                      clk,
	input wire                      arst_n,
	input wire                      req_valid,
	input wire                      req_stall,
	input wire rimt_pkg::in_item_t  req,
	input wire                      rsp_valid,
	input wire                      rsp_stall,
	input wire rimt_pkg::out_item_t rsp
);

	// a miss never carries a time
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.request_time == '0)
		else $error("miss response with nonzero time");

	// a match beat holds off the next item
	a_match_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.operation == rimt_pkg::OP_MATCH |=> req_stall)
		else $error("block ready right after a match beat");

	// a register beat leaves the block ready for the next item
	a_reg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.operation == rimt_pkg::OP_REGISTER |=> !req_stall)
		else $error("block stalled after a register beat");

	// a stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response beat changed");

endmodule

bind request_id_match_tracker_unit rimt_checker u_rimt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire

### sim/request_id_match_tracker_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// request_id_match_tracker_unit_tb: self-checking bench for the id match table
// Sends register and match beats. A scoreboard keeps its own copy of the
// request ring and predicts every response beat, including ties and the
// clearing of earlier entries. Random idle time is applied on both channels,
// and one long response hold fills the block.
// ----------------------------------------------------------------------------

module request_id_match_tracker_unit_tb;

	import rimt_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 2 * ENTRIES + 8;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	in_item_t  req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	out_item_t rsp;

	// scoreboard copy of the request ring
	logic      ring_live [ENTRIES];
	id_t       ring_id   [ENTRIES];
	ts_t       ring_time [ENTRIES];
	idx_t      ring_wr_ptr;

	out_item_t pending_answers [$];

	int errors = 0;
	int n_registered = 0;
	int n_matched = 0;
	int n_found = 0;

	bit req_gaps_on = 1'b0;
	bit rsp_gaps_on = 1'b0;
	int hold_len = 0;

	request_id_match_tracker_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #1 clk = ~clk;

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic ts_t rand_time();
		return ts_t'({$urandom, $urandom});
	endfunction

	// earliest live entry with the id wins, lowest index on a tie;
	// a hit retires it and every live entry sent strictly earlier
	function automatic void track_beat(input in_item_t beat);
		out_item_t ans;
		int pick;
		if (beat.operation == OP_REGISTER) begin
			ring_live[ring_wr_ptr] = 1'b1;
			ring_id[ring_wr_ptr] = beat.message_id;
			ring_time[ring_wr_ptr] = beat.timestamp;
			ring_wr_ptr = (ring_wr_ptr == idx_t'(ENTRIES - 1)) ? '0 : ring_wr_ptr + 1'b1;
			n_registered++;
		end else begin
			pick = -1;
			for (int i = 0; i < ENTRIES; i++) begin
				if (ring_live[i] && ring_id[i] == beat.message_id &&
						(pick < 0 || ring_time[i] < ring_time[pick]))
					pick = i;
			end
			ans = '0;
			if (pick >= 0) begin
				ans.found = 1'b1;
				ans.request_time = ring_time[pick];
				for (int i = 0; i < ENTRIES; i++) begin
					if (ring_live[i] && ring_time[i] < ans.request_time)
						ring_live[i] = 1'b0;
				end
				ring_live[pick] = 1'b0;
				n_found++;
			end
			pending_answers.push_back(ans);
			n_matched++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : scoreboard
		out_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++)
				ring_live[i] = 1'b0;
			ring_wr_ptr = '0;
		end else begin
			if (req_valid && !req_stall)
				track_beat(req);
			if (rsp_valid && !rsp_stall) begin
				if (pending_answers.size() == 0) begin
					$error("response beat with no match pending");
					errors++;
				end else begin
					want = pending_answers.pop_front();
					if (rsp.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, rsp.found);
						errors++;
					end
					if (rsp.request_time !== want.request_time) begin
						$error("request_time: expected %0d, got %0d",
							want.request_time, rsp.request_time);
						errors++;
					end
				end
			end
		end
	end

	// response side stall; a requested hold overrides the random pattern
	always begin : rsp_side
		int n;
		@(posedge clk);
		if (hold_len > 0) begin
			n = hold_len;
			hold_len = 0;
		end else if (rsp_gaps_on) begin
			n = gap_len();
		end else begin
			n = 0;
		end
		if (n > 0) begin
			rsp_stall <= 1'b1;
			repeat (n) @(posedge clk);
		end
		rsp_stall <= 1'b0;
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle = 0;
			else
				idle++;
		end
		$display("request_id_match_tracker_unit_tb failed");
		$finish;
	end

	// offer one beat and hold it until taken
	task automatic send_beat(input logic op, input id_t id, input ts_t ts);
		int gap;
		req <= '{operation: op, message_id: id, timestamp: ts};
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		gap = req_gaps_on ? gap_len() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// called right at an accept edge: drop valid, then wait for all answers
	task automatic wait_drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_answers.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_table();
		send_beat(OP_MATCH, 16'h0000, rand_time());
		send_beat(OP_MATCH, 16'hFFFF, '1);
	endtask

	task automatic test_field_extremes();
		send_beat(OP_REGISTER, 16'h0000, '0);
		send_beat(OP_REGISTER, 16'hFFFF, '1);
		send_beat(OP_REGISTER, 16'h0000, '1);
		send_beat(OP_MATCH, 16'h0000, '1);
		// equal time is not strictly earlier, so the id 0 max entry stays
		send_beat(OP_MATCH, 16'hFFFF, '0);
		send_beat(OP_MATCH, 16'h0000, '0);
		send_beat(OP_MATCH, 16'h0000, '0);
	endtask

	task automatic test_tie_lowest_index();
		send_beat(OP_REGISTER, 16'h0005, ts_t'(100));
		send_beat(OP_REGISTER, 16'h0005, ts_t'(100));
		send_beat(OP_MATCH, 16'h0005, '0);
		send_beat(OP_MATCH, 16'h0005, '0);
		send_beat(OP_MATCH, 16'h0005, '0);
	endtask

	task automatic test_clears_earlier();
		send_beat(OP_REGISTER, 16'h0001, ts_t'(50));
		send_beat(OP_REGISTER, 16'h0002, ts_t'(10));
		send_beat(OP_REGISTER, 16'h0003, ts_t'(70));
		send_beat(OP_REGISTER, 16'h0004, ts_t'(60));
		send_beat(OP_MATCH, 16'h0003, '0);
		send_beat(OP_MATCH, 16'h0002, '0);
		send_beat(OP_MATCH, 16'h0004, '0);
	endtask

	// a full lap of the ring lands on a slot that is still outstanding
	task automatic test_overwrite_outstanding();
		send_beat(OP_REGISTER, 16'h0A0A, ts_t'(1));
		for (int k = 0; k < ENTRIES - 1; k++)
			send_beat(OP_REGISTER, id_t'(16'h0B00 + k), ts_t'(2000 + k));
		send_beat(OP_REGISTER, 16'h0C0C, ts_t'(3000));
		send_beat(OP_MATCH, 16'h0A0A, '0);
		send_beat(OP_MATCH, 16'h0C0C, '0);
		send_beat(OP_MATCH, 16'h0B05, '0);
	endtask

	// ids mostly from a small pool so matches hit; times mostly rising
	task automatic run_traffic(input int count);
		id_t pool [8];
		ts_t now_us;
		ts_t ts;
		id_t id;
		int r;
		for (int k = 0; k < 8; k++)
			pool[k] = id_t'($urandom);
		now_us = ts_t'($urandom_range(0, 1000));
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 55) begin
				id = ($urandom_range(0, 9) == 0) ? id_t'($urandom) : pool[$urandom_range(0, 7)];
				r = $urandom_range(0, 99);
				if (r < 70) begin
					now_us = now_us + ts_t'($urandom_range(0, 40));
					ts = now_us;
				end else if (r < 90) begin
					ts = rand_time();
				end else if (r < 95) begin
					ts = '0;
				end else begin
					ts = '1;
				end
				send_beat(OP_REGISTER, id, ts);
			end else begin
				id = ($urandom_range(0, 3) == 0) ? id_t'($urandom) : pool[$urandom_range(0, 7)];
				send_beat(OP_MATCH, id, rand_time());
			end
		end
	endtask

	task automatic test_traffic_idle_both();
		req_gaps_on = 1'b1;
		rsp_gaps_on = 1'b1;
		run_traffic(300);
	endtask

	task automatic test_traffic_no_idle();
		req_gaps_on = 1'b0;
		rsp_gaps_on = 1'b0;
		run_traffic(150);
	endtask

	// long response hold while matches keep coming, so the input stalls
	task automatic test_backpressure_fill();
		req_gaps_on = 1'b0;
		hold_len = HOLD_CYCLES;
		send_beat(OP_REGISTER, 16'h1234, ts_t'(5));
		send_beat(OP_REGISTER, 16'h1234, ts_t'(7));
		for (int k = 0; k < 6; k++)
			send_beat(OP_MATCH, 16'h1234, rand_time());
		wait_drain();
	endtask

	task automatic test_traffic_mixed();
		req_gaps_on = 1'b1;
		rsp_gaps_on = 1'b1;
		run_traffic(120);
		wait_drain();
		run_traffic(120);
		req_gaps_on = 1'b0;
		run_traffic(60);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		req_gaps_on = 1'b1;
		rsp_gaps_on = 1'b1;
		test_empty_table();
		test_field_extremes();
		test_tie_lowest_index();
		test_clears_earlier();
		test_overwrite_outstanding();
		test_traffic_idle_both();
		test_traffic_no_idle();
		test_backpressure_fill();
		test_traffic_mixed();

		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d register beats and %0d match beats (%0d hits)",
			n_registered, n_matched, n_found);
		$display("with random idle on both channels, idle-free runs and a %0d-cycle hold",
			HOLD_CYCLES);
		if (errors == 0)
			$display("request_id_match_tracker_unit_tb passed");
		else
			$display("request_id_match_tracker_unit_tb failed");
		$finish;
	end

endmodule
